>>> rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent checks with a synchronous reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cond must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/rrip_pkg.sv
// -----------------------------------------------------------------------------
// rrip_pkg
// Geometry, entry layout and shared helpers of the RRIP tag lookup.
// -----------------------------------------------------------------------------
`default_nettype none

package rrip_pkg;

   // geometry; SETS and BLOCK_BYTES are powers of two
   localparam int SETS         = 64;
   localparam int WAYS         = 8;
   localparam int BLOCK_BYTES  = 64;
   localparam int ADDR_BITS    = 48;
   localparam int DRAW_BITS    = 7;
   localparam int CNT_BITS     = 32;
   localparam int WAY_OUT_BITS = 3;

   localparam int OFFSET_BITS  = $clog2(BLOCK_BYTES);
   localparam int SET_BITS     = $clog2(SETS);
   localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_BITS     = ADDR_BITS - OFFSET_BITS - SET_BITS;

   localparam logic [1:0] RRPV_MAX  = 2'd3;
   localparam logic [1:0] RRPV_NEAR = 2'd2;

   // configuration register indexes
   localparam logic CSR_POLICY_MODE  = 1'b0;
   localparam logic CSR_NEAR_PERCENT = 1'b1;

   localparam logic POLICY_SRRIP = 1'b0;

   typedef logic [SET_IDX_BITS-1:0] set_idx_type;
   typedef logic [TAG_BITS-1:0]     tag_type;
   typedef logic [WAY_BITS-1:0]     way_idx_type;

   typedef struct packed {
      tag_type    tag;
      logic       valid;
      logic [1:0] rrpv;
   } way_entry_type;

   typedef way_entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic        hit;
      way_idx_type way;
      row_type     row;
   } lookup_result_type;

   function automatic set_idx_type set_of(input logic [ADDR_BITS-1:0] addr);
      logic [ADDR_BITS-1:0] block;
      block  = addr >> OFFSET_BITS;
      set_of = SET_IDX_BITS'(block % SETS);
   endfunction

   function automatic tag_type tag_of(input logic [ADDR_BITS-1:0] addr);
      logic [ADDR_BITS-1:0] block;
      block  = addr >> OFFSET_BITS;
      tag_of = TAG_BITS'(block / SETS);
   endfunction

endpackage

`default_nettype wire

>>> rtl/rrip_tag_ram.sv
// -----------------------------------------------------------------------------
// rrip_tag_ram
// One row per set holding tag, valid and RRPV of every way. Registered
// read; a row never written since reset reads as all zero.
// -----------------------------------------------------------------------------
`default_nettype none

module rrip_tag_ram
   import rrip_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rd_en,
   input  wire set_idx_type rd_addr,
   output      row_type     rd_row,
   input  wire logic        wr_en,
   input  wire set_idx_type wr_addr,
   input  wire row_type     wr_row
);

   row_type            row_mem [SETS];
   logic [SETS-1:0]    row_valid_ff;
   row_type            rd_row_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // untouched rows stand for the all-zero reset contents
   assign rd_row = rd_valid_ff ? rd_row_ff : '0;

endmodule

`default_nettype wire

>>> rtl/rrip_way_ctrl.sv
// -----------------------------------------------------------------------------
// rrip_way_ctrl
// Tag compare, victim search with aging, and the updated row for write-back.
// -----------------------------------------------------------------------------
`default_nettype none

module rrip_way_ctrl
   import rrip_pkg::*;
(
   input  wire row_type                row_in,
   input  wire tag_type                tag,
   input  wire logic                   policy_mode,
   input  wire logic [DRAW_BITS-1:0]   near_insert_percent,
   input  wire logic [DRAW_BITS-1:0]   random_draw,
   output      lookup_result_type      result
);

   logic [WAYS-1:0] hit_vec;
   way_idx_type     hit_way;
   way_idx_type     victim_way;
   logic [1:0]      top_rrpv;
   logic [1:0]      age_by;
   logic [1:0]      insert_rrpv;
   row_type         aged_row;
   row_type         hit_row;

   always_comb begin
      hit_vec = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = row_in[w].valid && (row_in[w].tag == tag);
      end
   end

   // lowest way wins: scan downward so the last write is the lowest
   always_comb begin
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      top_rrpv = 2'd0;
      for (int w = 0; w < WAYS; w++) begin
         if (row_in[w].rrpv > top_rrpv) begin
            top_rrpv = row_in[w].rrpv;
         end
      end
   end

   always_comb begin
      victim_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_in[w].rrpv == top_rrpv) begin
            victim_way = WAY_BITS'(w);
         end
      end
   end

   assign age_by = RRPV_MAX - top_rrpv;

   always_comb begin
      if (policy_mode == POLICY_SRRIP) begin
         insert_rrpv = RRPV_NEAR;
      end else begin
         insert_rrpv = (random_draw < near_insert_percent) ? RRPV_NEAR : RRPV_MAX;
      end
   end

   always_comb begin
      aged_row = row_in;
      for (int w = 0; w < WAYS; w++) begin
         aged_row[w].rrpv = row_in[w].rrpv + age_by;
      end
      aged_row[victim_way].tag   = tag;
      aged_row[victim_way].valid = 1'b1;
      aged_row[victim_way].rrpv  = insert_rrpv;
   end

   always_comb begin
      hit_row               = row_in;
      hit_row[hit_way].rrpv = 2'd0;
   end

   always_comb begin
      result.hit = |hit_vec;
      result.way = (|hit_vec) ? hit_way : victim_way;
      result.row = (|hit_vec) ? hit_row : aged_row;
   end

endmodule

`default_nettype wire

>>> rtl/rrip_set_assoc_cache_lookup.sv
// -----------------------------------------------------------------------------
// rrip_set_assoc_cache_lookup
// Set-associative tag lookup with 2-bit RRIP replacement (SRRIP / BRRIP).
//
//   Channel  Ports                                   Direction
//   req      req_valid/req_ready, address, draw      in
//   rsp      rsp_valid/rsp_ready, hit, way, totals   out
//   csr      csr_wr_en, csr_index, csr_wr_data       in, write only
//
// The set row is read from the tag RAM at accept, then compared, updated
// and written back in the lookup state once the result register is free.
// The read-modify-write of one row completes before the next item is taken,
// so back-to-back items on one set always see the updated row.
// Reset clears counters, registers and the per-row valid flags at once;
// there is no clearing pass. A held result stalls only the write-back cycle.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrip_set_assoc_cache_lookup
   import rrip_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [ADDR_BITS-1:0]  req_access_address,
   input  wire logic [DRAW_BITS-1:0]  req_random_draw,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_was_hit,
   output      logic [WAY_OUT_BITS-1:0] rsp_way_used,
   output      logic [CNT_BITS-1:0]   rsp_hit_total,
   output      logic [CNT_BITS-1:0]   rsp_miss_total,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_index,
   input  wire logic [DRAW_BITS-1:0]  csr_wr_data
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic                    state_ff, state_in;
   logic                    accept;
   logic                    commit;

   set_idx_type             set_ff;
   tag_type                 tag_ff;
   logic [DRAW_BITS-1:0]    draw_ff;

   logic                    policy_ff;
   logic [DRAW_BITS-1:0]    percent_ff;

   logic [CNT_BITS-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [CNT_BITS-1:0]     miss_cnt_ff, miss_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff;
   logic [WAY_OUT_BITS-1:0] rsp_way_ff;
   logic [CNT_BITS-1:0]     rsp_hit_total_ff;
   logic [CNT_BITS-1:0]     rsp_miss_total_ff;

   row_type                 rd_row;
   lookup_result_type       lookup;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // write back only when the output register can take the item
   assign commit    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   rrip_tag_ram u_tag_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (set_of(req_access_address)),
      .rd_row  (rd_row),
      .wr_en   (commit),
      .wr_addr (set_ff),
      .wr_row  (lookup.row)
   );

   rrip_way_ctrl u_way_ctrl (
      .row_in              (rd_row),
      .tag                 (tag_ff),
      .policy_mode         (policy_ff),
      .near_insert_percent (percent_ff),
      .random_draw         (draw_ff),
      .result              (lookup)
   );

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = accept ? ST_LOOKUP : ST_IDLE;
         ST_LOOKUP: state_in = commit ? ST_IDLE : ST_LOOKUP;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (commit) begin
         if (lookup.hit) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end else begin
            miss_cnt_in = miss_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         policy_ff    <= POLICY_SRRIP;
         percent_ff   <= DRAW_BITS'(10);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_POLICY_MODE:  policy_ff  <= csr_wr_data[0];
               CSR_NEAR_PERCENT: percent_ff <= csr_wr_data;
               default:          policy_ff  <= policy_ff;
            endcase
         end
      end
   end

   // hold the item's fields for the lookup state; capture the result at write-back
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff  <= set_of(req_access_address);
         tag_ff  <= tag_of(req_access_address);
         draw_ff <= req_random_draw;
      end
      if (commit) begin
         rsp_hit_ff        <= lookup.hit;
         rsp_way_ff        <= WAY_OUT_BITS'(lookup.way);
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_was_hit    = rsp_hit_ff;
   assign rsp_way_used   = rsp_way_ff;
   assign rsp_hit_total  = rsp_hit_total_ff;
   assign rsp_miss_total = rsp_miss_total_ff;

   `ASSERT_CLK(a_one_count_per_item, clock, reset, commit |=> ((hit_cnt_ff + miss_cnt_ff) == ($past(hit_cnt_ff + miss_cnt_ff) + 32'd1)), "counters must advance by one per item")
   `ASSERT_CLK(a_accept_blocks_next, clock, reset, accept |=> !req_ready, "no item accepted in the lookup cycle")
   `ASSERT_CLK(a_commit_shows_rsp, clock, reset, commit |=> (rsp_valid && (rsp_hit_total == hit_cnt_ff) && (rsp_miss_total == miss_cnt_ff)), "result must carry the updated totals")
   `ASSERT_NEVER(a_commit_only_on_free, clock, reset, commit && rsp_valid_ff && !rsp_ready, "write-back over an untaken result")

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Checks the RRIP tag lookup against its own model of tags, valid bits,
// prediction values and hit/miss totals: directed accesses for address
// extremes, set fill and eviction with aging, and bimodal insertion edges,
// then random traffic on hot sets under several policy settings, with
// random gaps and stalls on both channels.
// -----------------------------------------------------------------------------

module testbench;
   import rrip_pkg::*;

   localparam logic       POLICY_BRRIP       = 1'b1;
   localparam logic [6:0] NEAR_PERCENT_RESET = 7'd10;
   localparam int         TAG_POOL_SIZE      = 12;

   typedef struct packed {
      logic                    was_hit;
      logic [WAY_OUT_BITS-1:0] way_used;
      logic [CNT_BITS-1:0]     hit_total;
      logic [CNT_BITS-1:0]     miss_total;
   } lookup_outcome_type;

   logic                    clock;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic                    req_ready;
   logic [ADDR_BITS-1:0]    req_access_address = '0;
   logic [DRAW_BITS-1:0]    req_random_draw    = '0;
   logic                    rsp_valid;
   logic                    rsp_ready          = 1'b0;
   logic                    rsp_was_hit;
   logic [WAY_OUT_BITS-1:0] rsp_way_used;
   logic [CNT_BITS-1:0]     rsp_hit_total;
   logic [CNT_BITS-1:0]     rsp_miss_total;
   logic                    csr_wr_en          = 1'b0;
   logic                    csr_index          = CSR_POLICY_MODE;
   logic [DRAW_BITS-1:0]    csr_wr_data        = '0;

   // model of the cache state
   tag_type             line_tag   [SETS][WAYS];
   logic                line_valid [SETS][WAYS];
   logic [1:0]          line_rrpv  [SETS][WAYS];
   logic [CNT_BITS-1:0] hits_seen;
   logic [CNT_BITS-1:0] misses_seen;
   logic                policy_reg;
   logic [6:0]          near_percent_reg;

   lookup_outcome_type pending_outcomes[$];
   int                 mismatch_count = 0;
   bit                 source_steady  = 1'b0;
   bit                 sink_steady    = 1'b0;
   int                 stall_left     = 0;
   tag_type            tag_pool [TAG_POOL_SIZE];

   rrip_set_assoc_cache_lookup u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_access_address (req_access_address),
      .req_random_draw    (req_random_draw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_was_hit        (rsp_was_hit),
      .rsp_way_used       (rsp_way_used),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   function automatic void clear_cache_model();
      for (int s = 0; s < SETS; s++) begin
         for (int w = 0; w < WAYS; w++) begin
            line_tag[s][w]   = '0;
            line_valid[s][w] = 1'b0;
            line_rrpv[s][w]  = 2'd0;
         end
      end
      hits_seen        = '0;
      misses_seen      = '0;
      policy_reg       = POLICY_SRRIP;
      near_percent_reg = NEAR_PERCENT_RESET;
   endfunction

   function automatic lookup_outcome_type predict_lookup(input logic [ADDR_BITS-1:0] addr,
                                                         input logic [DRAW_BITS-1:0] draw);
      lookup_outcome_type res;
      set_idx_type        s;
      tag_type            t;
      bit                 found;
      int                 way;
      logic [1:0]         top;
      s     = set_idx_type'(addr >> OFFSET_BITS);
      t     = tag_type'(addr >> (OFFSET_BITS + SET_BITS));
      found = 1'b0;
      way   = 0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && line_valid[s][w] && line_tag[s][w] == t) begin
            found = 1'b1;
            way   = w;
         end
      end
      if (found) begin
         hits_seen         = hits_seen + 1'b1;
         line_rrpv[s][way] = 2'd0;
      end else begin
         misses_seen = misses_seen + 1'b1;
         // lowest way holding the largest value, then age the set so it reaches max
         top = line_rrpv[s][0];
         for (int w = 1; w < WAYS; w++) begin
            if (line_rrpv[s][w] > top) begin
               top = line_rrpv[s][w];
               way = w;
            end
         end
         for (int w = 0; w < WAYS; w++)
            line_rrpv[s][w] = line_rrpv[s][w] + (RRPV_MAX - top);
         if (policy_reg == POLICY_SRRIP)
            line_rrpv[s][way] = RRPV_NEAR;
         else
            line_rrpv[s][way] = (draw < near_percent_reg) ? RRPV_NEAR : RRPV_MAX;
         line_tag[s][way]   = t;
         line_valid[s][way] = 1'b1;
      end
      res.was_hit    = found;
      res.way_used   = WAY_OUT_BITS'(way);
      res.hit_total  = hits_seen;
      res.miss_total = misses_seen;
      return res;
   endfunction

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [ADDR_BITS-1:0] form_address(input tag_type t, input set_idx_type s,
                                                         input logic [OFFSET_BITS-1:0] off);
      return {t, s, off};
   endfunction

   // result side: check each item, then pick the next ready level
   always @(posedge clock) begin : check_rsp
      lookup_outcome_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result item: hit %0b way %0d hits %0d misses %0d",
                        $time, rsp_was_hit, rsp_way_used, rsp_hit_total, rsp_miss_total);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_was_hit !== want.was_hit) begin
                  mismatch_count++;
                  $display("%0t: was_hit expected %0b actual %0b",
                           $time, want.was_hit, rsp_was_hit);
               end
               if (rsp_way_used !== want.way_used) begin
                  mismatch_count++;
                  $display("%0t: way_used expected %0d actual %0d",
                           $time, want.way_used, rsp_way_used);
               end
               if (rsp_hit_total !== want.hit_total) begin
                  mismatch_count++;
                  $display("%0t: hit_total expected %0d actual %0d",
                           $time, want.hit_total, rsp_hit_total);
               end
               if (rsp_miss_total !== want.miss_total) begin
                  mismatch_count++;
                  $display("%0t: miss_total expected %0d actual %0d",
                           $time, want.miss_total, rsp_miss_total);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_ready  <= 1'b1;
            if (!sink_steady && $urandom_range(0, 2) == 0)
               stall_left = pick_gap(1'b0);
         end
      end
   end

   task automatic send_access(input logic [ADDR_BITS-1:0] addr,
                              input logic [DRAW_BITS-1:0] draw);
      int gap;
      gap = pick_gap(source_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_access_address <= addr;
      req_random_draw    <= draw;
      pending_outcomes.push_back(predict_lookup(addr, draw));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold the sender until every outstanding item has been answered
   task automatic wait_for_outcomes();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [DRAW_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_POLICY_MODE)
         policy_reg = data[0];
      else
         near_percent_reg = data;
      @(posedge clock);
   endtask

   task automatic test_address_extremes();
      send_access('0, 7'd0);
      send_access('0, 7'd127);
      send_access('1, 7'd127);
      send_access({{(ADDR_BITS-OFFSET_BITS){1'b1}}, {OFFSET_BITS{1'b0}}}, 7'd0);
   endtask

   // fill every way of one set, then evict with aging and re-touch lines
   task automatic test_set_fill_and_eviction();
      set_idx_type s;
      s = set_idx_type'(5);
      for (int i = 0; i < WAYS; i++)
         send_access(form_address(tag_type'(256 + i), s, OFFSET_BITS'(i)), 7'd50);
      send_access(form_address(tag_type'(256 + 3), s, '0), 7'd50);
      send_access(form_address(tag_type'(256), s, '1), 7'd50);
      send_access(form_address(tag_type'(256 + WAYS), s, '0), 7'd50);
      send_access(form_address(tag_type'(256 + 1), s, '0), 7'd50);
      send_access(form_address(tag_type'(256 + 3), s, '0), 7'd50);
   endtask

   // draws at and around the percent threshold, including out-of-range values
   task automatic test_bimodal_insertion();
      set_idx_type s;
      s = set_idx_type'(9);
      wait_for_outcomes();
      write_csr(CSR_POLICY_MODE, 7'(POLICY_BRRIP));
      send_access(form_address(tag_type'(512), s, '0), 7'd9);
      send_access(form_address(tag_type'(513), s, '0), 7'd10);
      send_access(form_address(tag_type'(514), s, '0), 7'd127);
      wait_for_outcomes();
      write_csr(CSR_NEAR_PERCENT, 7'd127);
      send_access(form_address(tag_type'(515), s, '0), 7'd99);
      send_access(form_address(tag_type'(516), s, '0), 7'd127);
      wait_for_outcomes();
      write_csr(CSR_NEAR_PERCENT, 7'd0);
      send_access(form_address(tag_type'(517), s, '0), 7'd0);
      send_access(form_address(tag_type'(518), s, '0), 7'd0);
      send_access(form_address(tag_type'(512), s, '0), 7'd0);
   endtask

   function automatic logic [ADDR_BITS-1:0] random_address();
      tag_type     t;
      set_idx_type s;
      if ($urandom_range(0, 99) < 85)
         t = tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)];
      else
         t = tag_type'({$urandom, $urandom});
      if ($urandom_range(0, 99) < 75)
         s = set_idx_type'($urandom_range(0, 3));
      else
         s = set_idx_type'($urandom);
      return form_address(t, s, OFFSET_BITS'($urandom));
   endfunction

   task automatic run_phase(input logic mode, input logic [6:0] percent, input int count);
      logic [DRAW_BITS-1:0] draw;
      wait_for_outcomes();
      write_csr(CSR_POLICY_MODE, 7'(mode));
      write_csr(CSR_NEAR_PERCENT, percent);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 59) == 0)
            wait_for_outcomes();
         if ($urandom_range(0, 99) < 80)
            draw = DRAW_BITS'($urandom_range(0, 99));
         else
            draw = DRAW_BITS'($urandom_range(0, 127));
         send_access(random_address(), draw);
      end
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < TAG_POOL_SIZE; i++)
         tag_pool[i] = tag_type'({$urandom, $urandom});
      run_phase(POLICY_SRRIP, NEAR_PERCENT_RESET, 110);
      run_phase(POLICY_BRRIP, 7'd50, 110);
      run_phase(POLICY_BRRIP, 7'd0, 100);
      run_phase(POLICY_BRRIP, 7'd100, 110);
      run_phase(POLICY_BRRIP, 7'd127, 100);
      run_phase(POLICY_SRRIP, 7'd1, 110);
   endtask

   initial begin
      clear_cache_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_address_extremes();
      test_set_fill_and_eviction();
      test_bimodal_insertion();
      test_random_traffic();
      wait_for_outcomes();
      if (pending_outcomes.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d result items never arrived", $time, pending_outcomes.size());
      end
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
